@@ hdl/afbms_pkg.sv @@
// Shared types and constants for the audio format best-match selector.
// No dependencies; used by every module of the block.
`default_nettype none

package afbms_pkg;

  // Field widths fixed by the stream format
  localparam int CHAN_W      = 8;
  localparam int RES_W       = 8;
  localparam int SUBSLOT_W   = 8;
  localparam int RATE_W      = 32;
  localparam int CONT_W      = SUBSLOT_W + 3;  // subslot bytes times 8
  localparam int STATUS_W    = 2;
  localparam int ALT_INDEX_W = 5;

  localparam int IN_TDATA_W  = 120;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 8;

  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;

  localparam int MAX_ALTS_DEF = 32;
  localparam int QUEUE_DEPTH  = 2;

  // Register indexes on the configuration channel
  localparam logic [CFG_IDX_W-1:0] REG_WANTED_RATE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WANTED_CHANNELS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WANTED_BITS     = 2'd2;

  // Register reset values
  localparam logic [RATE_W-1:0] WANTED_RATE_RST     = 32'd48000;
  localparam logic [CHAN_W-1:0] WANTED_CHANNELS_RST = 8'd2;
  localparam logic [RES_W-1:0]  WANTED_BITS_RST     = 8'd16;

  typedef logic [STATUS_W-1:0] status_t;

  localparam status_t ST_FOUND      = 2'd0;
  localparam status_t ST_NO_CHANNEL = 2'd1;
  localparam status_t ST_NO_WIDTH   = 2'd2;
  localparam status_t ST_NO_RATE    = 2'd3;

  // Classified item as passed from front to back
  typedef struct packed {
    logic              end_list;
    logic              end_alt;
    logic              ch_ok;
    logic              width_ok;
    logic              exact_hit;
    logic              range_valid;
    logic              in_range;
    logic              present;
    logic [CONT_W-1:0] container;
    logic [RES_W-1:0]  res;
  } cls_t;

endpackage

`default_nettype wire

@@ hdl/afbms_front.sv @@
// Front end: configuration registers and per-beat classification.
// Depends on afbms_pkg; feeds afbms_queue through a one-stage register.
`default_nettype none

module afbms_front (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // configuration
  input  wire logic                                cfg_valid,
  input  wire logic [afbms_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [afbms_pkg::CFG_DATA_W-1:0]    cfg_data,
  // input stream
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire logic [afbms_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  wire logic [afbms_pkg::IN_TUSER_W-1:0]    in_tuser,
  input  wire logic                                in_tlast,
  // to queue
  output logic                                     f_valid,
  input  wire logic                                f_ready,
  output afbms_pkg::cls_t                          f_rec
);

  logic [afbms_pkg::RATE_W-1:0] wanted_rate_r;
  logic [afbms_pkg::CHAN_W-1:0] wanted_channels_r;
  logic [afbms_pkg::RES_W-1:0]  wanted_bits_r;

  logic                         f_valid_r, f_valid_nxt;
  afbms_pkg::cls_t              f_rec_r;
  afbms_pkg::cls_t              cls;

  logic [afbms_pkg::CHAN_W-1:0]    alt_channels;
  logic [afbms_pkg::RES_W-1:0]     alt_resolution;
  logic [afbms_pkg::SUBSLOT_W-1:0] alt_subslot_bytes;
  logic [afbms_pkg::RATE_W-1:0]    alt_rate_min;
  logic [afbms_pkg::RATE_W-1:0]    alt_rate_max;
  logic [afbms_pkg::RATE_W-1:0]    listed_rate;
  logic                            in_acc;

  assign alt_channels      = in_tdata[7:0];
  assign alt_resolution    = in_tdata[15:8];
  assign alt_subslot_bytes = in_tdata[23:16];
  assign alt_rate_min      = in_tdata[55:24];
  assign alt_rate_max      = in_tdata[87:56];
  assign listed_rate       = in_tdata[119:88];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wanted_rate_r     <= afbms_pkg::WANTED_RATE_RST;
      wanted_channels_r <= afbms_pkg::WANTED_CHANNELS_RST;
      wanted_bits_r     <= afbms_pkg::WANTED_BITS_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        afbms_pkg::REG_WANTED_RATE:     wanted_rate_r     <= cfg_data;
        afbms_pkg::REG_WANTED_CHANNELS: wanted_channels_r <= cfg_data[7:0];
        afbms_pkg::REG_WANTED_BITS:     wanted_bits_r     <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cls           = '0;
    cls.end_list  = in_tlast;
    cls.end_alt   = in_tuser[1];
    cls.present   = in_tuser[0];
    cls.res       = alt_resolution;
    cls.container = {alt_subslot_bytes, 3'b000};
    cls.ch_ok     = (alt_channels == wanted_channels_r);
    cls.width_ok  = (alt_resolution >= wanted_bits_r) &&
                    (cls.container >= {3'b000, alt_resolution});
    cls.exact_hit = in_tuser[0] && (listed_rate == wanted_rate_r);
    cls.range_valid = (alt_rate_min != '0) && (alt_rate_max >= alt_rate_min);
    cls.in_range  = (wanted_rate_r >= alt_rate_min) && (wanted_rate_r <= alt_rate_max);
  end

  assign in_tready = !f_valid_r || f_ready;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    f_valid_nxt = f_valid_r;
    if (in_acc)
      f_valid_nxt = 1'b1;
    else if (f_ready)
      f_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n)
      f_valid_r <= 1'b0;
    else
      f_valid_r <= f_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (in_acc)
      f_rec_r <= cls;
  end

  assign f_valid = f_valid_r;
  assign f_rec   = f_rec_r;

endmodule

`default_nettype wire

@@ hdl/afbms_queue.sv @@
// Short queue of classified beats between front and back.
// Depends on afbms_pkg for the record type and depth.
`default_nettype none

module afbms_queue (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push_valid,
  output logic                  push_ready,
  input  wire afbms_pkg::cls_t  push_rec,
  output logic                  pop_valid,
  input  wire logic             pop_ready,
  output afbms_pkg::cls_t       pop_rec
);

  localparam int DEPTH = afbms_pkg::QUEUE_DEPTH;
  localparam int PW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  afbms_pkg::cls_t mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            do_push, do_pop;

  assign push_ready = (count_r != CW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_rec    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push)
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    if (do_pop)
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    if (do_push && !do_pop)
      count_nxt = count_r + 1'b1;
    else if (do_pop && !do_push)
      count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push)
      mem_r[wr_ptr_r] <= push_rec;
  end

endmodule

`default_nettype wire

@@ hdl/afbms_back.sv @@
// Back end: running best-match search over classified beats and result register.
// Depends on afbms_pkg; drains afbms_queue.
`default_nettype none

module afbms_back #(
  parameter int MAX_ALTS = afbms_pkg::MAX_ALTS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                q_valid,
  output logic                                     q_ready,
  input  wire afbms_pkg::cls_t                     q_rec,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic [afbms_pkg::OUT_TDATA_W-1:0]        out_tdata
);

  localparam int CW = $clog2(MAX_ALTS + 1);
  localparam int IW = afbms_pkg::ALT_INDEX_W;
  localparam int KW = afbms_pkg::CONT_W;
  localparam int RW = afbms_pkg::RES_W;

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          seen_ch_r, seen_ch_nxt;
  logic          seen_w_r, seen_w_nxt;
  logic          have_best_r, have_best_nxt;
  logic [IW-1:0] best_slot_r, best_slot_nxt;
  logic [KW-1:0] best_cont_r, best_cont_nxt;
  logic [RW-1:0] best_res_r, best_res_nxt;
  logic          rate_hit_r, rate_hit_nxt;

  logic                 out_valid_r, out_valid_nxt;
  afbms_pkg::status_t   out_status_r, out_status_nxt;
  logic [IW-1:0]        out_index_r, out_index_nxt;

  logic pop, active, closing, rate_ok, better;

  assign q_ready = !out_valid_r || out_tready;
  assign pop     = q_valid && q_ready;
  assign active  = (cnt_r < CW'(MAX_ALTS));
  assign closing = active && (q_rec.end_alt || q_rec.end_list);

  // exact listed hit wins, then a valid range, else only an empty rate list
  assign rate_ok = rate_hit_r || q_rec.exact_hit ||
                   (q_rec.range_valid ? q_rec.in_range : !q_rec.present);
  assign better  = !have_best_r || (q_rec.container < best_cont_r) ||
                   ((q_rec.container == best_cont_r) && (q_rec.res < best_res_r));

  always_comb begin
    cnt_nxt        = cnt_r;
    seen_ch_nxt    = seen_ch_r;
    seen_w_nxt     = seen_w_r;
    have_best_nxt  = have_best_r;
    best_slot_nxt  = best_slot_r;
    best_cont_nxt  = best_cont_r;
    best_res_nxt   = best_res_r;
    rate_hit_nxt   = rate_hit_r;
    out_status_nxt = out_status_r;
    out_index_nxt  = out_index_r;
    out_valid_nxt  = out_valid_r && !out_tready;

    if (pop) begin
      if (closing) begin
        rate_hit_nxt = 1'b0;
        cnt_nxt      = cnt_r + 1'b1;
        if (q_rec.ch_ok) begin
          seen_ch_nxt = 1'b1;
          if (q_rec.width_ok) begin
            seen_w_nxt = 1'b1;
            if (rate_ok && better) begin
              have_best_nxt = 1'b1;
              best_slot_nxt = IW'(cnt_r);
              best_cont_nxt = q_rec.container;
              best_res_nxt  = q_rec.res;
            end
          end
        end
      end else if (active && q_rec.exact_hit) begin
        rate_hit_nxt = 1'b1;
      end

      if (q_rec.end_list) begin
        out_valid_nxt = 1'b1;
        if (have_best_nxt) begin
          out_status_nxt = afbms_pkg::ST_FOUND;
          out_index_nxt  = best_slot_nxt;
        end else begin
          out_index_nxt = '0;
          if (!seen_ch_nxt)
            out_status_nxt = afbms_pkg::ST_NO_CHANNEL;
          else if (!seen_w_nxt)
            out_status_nxt = afbms_pkg::ST_NO_WIDTH;
          else
            out_status_nxt = afbms_pkg::ST_NO_RATE;
        end
        // new list starts with the next beat
        cnt_nxt       = '0;
        seen_ch_nxt   = 1'b0;
        seen_w_nxt    = 1'b0;
        have_best_nxt = 1'b0;
        best_slot_nxt = '0;
        best_cont_nxt = '0;
        best_res_nxt  = '0;
        rate_hit_nxt  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      seen_ch_r   <= 1'b0;
      seen_w_r    <= 1'b0;
      have_best_r <= 1'b0;
      best_slot_r <= '0;
      best_cont_r <= '0;
      best_res_r  <= '0;
      rate_hit_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      seen_ch_r   <= seen_ch_nxt;
      seen_w_r    <= seen_w_nxt;
      have_best_r <= have_best_nxt;
      best_slot_r <= best_slot_nxt;
      best_cont_r <= best_cont_nxt;
      best_res_r  <= best_res_nxt;
      rate_hit_r  <= rate_hit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_index_r  <= out_index_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_index_r, out_status_r};

endmodule

`default_nettype wire

@@ hdl/audio_format_best_match_select_core.sv @@
// Top level of the audio format best-match selector.
// Depends on afbms_pkg, afbms_front, afbms_queue and afbms_back.
`default_nettype none

// Takes one beat per rate entry of each format descriptor and one beat per
// clock when both sides keep up; a result is offered once the beat ending the
// list has passed the front register, the queue and the result register.
// The rate is set by the back end's search update, which folds one beat per
// cycle into the running best. Descriptor fields are taken from the beat that
// closes the descriptor; descriptors from index MAX_ALTS on are ignored.
// cfg_ready is always high; write the registers only while no list is in flight.
module audio_format_best_match_select_core #(
  parameter int MAX_ALTS = afbms_pkg::MAX_ALTS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // configuration: index 0 wanted_rate, 1 wanted_channels, 2 wanted_bits
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [afbms_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [afbms_pkg::CFG_DATA_W-1:0]    cfg_data,
  // input stream
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // alt_channels[7:0], alt_resolution[15:8], alt_subslot_bytes[23:16],
  // alt_rate_min[55:24], alt_rate_max[87:56], listed_rate[119:88]
  input  wire logic [afbms_pkg::IN_TDATA_W-1:0]    in_tdata,
  // rate_present[0], last_of_alt[1]
  input  wire logic [afbms_pkg::IN_TUSER_W-1:0]    in_tuser,
  input  wire logic                                in_tlast,  // last_alt
  // result stream
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // status[1:0], alt_index[6:2], zero[7]
  output logic [afbms_pkg::OUT_TDATA_W-1:0]        out_tdata
);

  logic            f_valid, f_ready;
  afbms_pkg::cls_t f_rec;
  logic            q_valid, q_ready;
  afbms_pkg::cls_t q_rec;

  assign cfg_ready = 1'b1;

  afbms_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .f_valid   (f_valid),
    .f_ready   (f_ready),
    .f_rec     (f_rec)
  );

  afbms_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_rec   (f_rec),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_rec    (q_rec)
  );

  afbms_back #(
    .MAX_ALTS (MAX_ALTS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_rec      (q_rec),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

`ifndef SYNTH
  // an error class never carries an index
  a_index_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tdata[1:0] != afbms_pkg::ST_FOUND)) |-> (out_tdata[6:2] == '0))
    else $error("error result with non-zero index");

  // a list-ending beat taken by the back end always shows a result next cycle
  a_result_follows_end: assert property (@(posedge clk) disable iff (!rst_n)
    (q_valid && q_ready && q_rec.end_list) |=> out_tvalid)
    else $error("list end drained without a result");

  // input back-pressure only while the front register is held by a full queue
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (f_valid && !f_ready))
    else $error("input stalled without a full queue");

  // a held front beat stays put until the queue takes it
  a_front_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (f_valid && !f_ready) |=> (f_valid && $stable(f_rec)))
    else $error("front beat lost while queue full");
`endif

endmodule

`default_nettype wire
